// ===== rtl/core/bsa_pkg.sv =====
// ----------------------------------------------------------------------------
// bsa_pkg
// Shared types and codes of the banker's safety allocator: beat payloads,
// action and status codes, register indexes and sequencer states.
// ----------------------------------------------------------------------------
package bsa_pkg;

    typedef struct packed {
        logic [2:0]  action;
        logic [3:0]  process_id;
        logic [3:0]  resource_id;
        logic [15:0] amount;
        logic        last_element;
    } bsa_in_t;

    typedef struct packed {
        logic [2:0] status;
        logic [3:0] order_process;
        logic       order_valid;
        logic       last;
    } bsa_out_t;

    typedef enum logic [2:0] {
        ACT_LOAD_AVAIL = 3'd0,
        ACT_LOAD_NEED  = 3'd1,
        ACT_LOAD_ALLOC = 3'd2,
        ACT_REQUEST    = 3'd3,
        ACT_CHECK      = 3'd4
    } action_t;

    typedef enum logic [2:0] {
        STAT_SAFE     = 3'd0,
        STAT_UNSAFE   = 3'd1,
        STAT_GRANTED  = 3'd2,
        STAT_DENIED   = 3'd3,
        STAT_INVALID  = 3'd4,
        STAT_LOAD_ERR = 3'd5
    } status_t;

    typedef enum logic {
        REG_PROCESS_COUNT  = 1'b0,
        REG_RESOURCE_COUNT = 1'b1
    } cfg_reg_t;

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_ALLOC_RD,
        S_ALLOC_EX,
        S_VAL_RD,
        S_VAL_EX,
        S_APP_RD,
        S_APP_EX,
        S_INIT_RD,
        S_INIT_EX,
        S_SCAN,
        S_FIT_RD,
        S_FIT_EX,
        S_ADD_RD,
        S_ADD_EX,
        S_RESOLVE,
        S_PCLR,
        S_EMIT,
        S_ORD_RD,
        S_ORD_EX
    } state_t;

endpackage

// ===== rtl/core/bankers_safety_allocator.sv =====
// ----------------------------------------------------------------------------
// bankers_safety_allocator
// Deadlock-avoidance allocator: holds available counts, allocation and
// remaining need in on-chip memories and runs the banker's safety test.
// ----------------------------------------------------------------------------
// After reset the block sweeps its stores to zero over all MAX_PROCESSES *
// MAX_RESOURCES entries with s_ready low; configuration writes are taken during
// the sweep. Items are handled one at a time by a sequencer around synchronous
// memories with registered reads, and every read-modify-write access is a read
// state followed by a compute/write state. A load of available or of maximum
// need, and a request element without the last mark, are written straight from
// the beat in idle; a load of allocation reads the need, then checks and writes.
// A safety check seeds the work vector from the available counts, then tests
// rows against it and adds the allocation of each row that passes; each pick
// restarts the scan at process 0, and each reported process then takes a read
// state and an emit state. A completed request runs validation, applies the
// request, runs the safety test, rolls back when unsafe, and clears all
// MAX_RESOURCES entries of the pending vector. A new beat is accepted as soon
// as the sequencer is back in idle, even while the previous result beat still
// waits on m_ready.
module bankers_safety_allocator
    import bsa_pkg::*;
#(
    parameter int MAX_PROCESSES = 16,
    parameter int MAX_RESOURCES = 16,
    parameter int COUNT_BITS    = 16
) (
    input  logic       aclk,
    input  logic       aresetn,
    // configuration
    input  logic       cfg_we,
    input  logic [0:0] cfg_index,
    input  logic [4:0] cfg_wdata,
    // item input
    input  logic       s_valid,
    output logic       s_ready,
    input  bsa_in_t    s_data,
    // result output
    output logic       m_valid,
    input  logic       m_ready,
    output bsa_out_t   m_data
);

    localparam int PIW       = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1;
    localparam int PCW       = $clog2(MAX_PROCESSES + 1);
    localparam int RIW       = (MAX_RESOURCES > 1) ? $clog2(MAX_RESOURCES) : 1;
    localparam int RCW       = $clog2(MAX_RESOURCES + 1);
    localparam int MAT_DEPTH = MAX_PROCESSES * MAX_RESOURCES;
    localparam int AW        = (MAT_DEPTH > 1) ? $clog2(MAT_DEPTH) : 1;
    localparam int WW        = COUNT_BITS + $clog2(MAX_PROCESSES + 1);

    // flat matrix address: process-major rows
    function automatic logic [AW-1:0] mat_addr(input logic [PIW-1:0] p,
                                               input logic [RIW-1:0] r);
        mat_addr = AW'(AW'(p) * AW'(MAX_RESOURCES) + AW'(r));
    endfunction

    // ------------------------------------------------------------------
    // memories
    // ------------------------------------------------------------------
    logic [COUNT_BITS-1:0] need_mem  [MAT_DEPTH];
    logic [COUNT_BITS-1:0] alloc_mem [MAT_DEPTH];
    logic [COUNT_BITS-1:0] avail_mem [MAX_RESOURCES];
    logic [COUNT_BITS-1:0] pend_mem  [MAX_RESOURCES];
    logic [WW-1:0]         work_mem  [MAX_RESOURCES];
    logic [PIW-1:0]        order_mem [MAX_PROCESSES];

    logic [COUNT_BITS-1:0] need_rd, alloc_rd, avail_rd, pend_rd;
    logic [WW-1:0]         work_rd;
    logic [PIW-1:0]        order_rd;

    logic                  need_we, alloc_we, avail_we, pend_we, work_we, order_we;
    logic [COUNT_BITS-1:0] need_wd, alloc_wd, avail_wd, pend_wd;
    logic [WW-1:0]         work_wd;
    logic [PIW-1:0]        order_wd;
    logic [AW-1:0]         mat_waddr, mat_raddr;
    logic [RIW-1:0]        vec_waddr;

    // ------------------------------------------------------------------
    // control and datapath registers
    // ------------------------------------------------------------------
    state_t                state_reg, state_next;
    logic [PCW-1:0]        pc_reg, pc_next;        // processes in use
    logic [RCW-1:0]        rc_reg, rc_next;        // resource kinds in use
    bsa_in_t               item_reg, item_next;
    logic [PCW-1:0]        proc_reg, proc_next;    // item process / clear row
    logic [RCW-1:0]        res_reg, res_next;      // resource loop index
    logic [PCW-1:0]        scan_reg, scan_next;    // safety scan process
    logic [PCW-1:0]        placed_reg, placed_next;// picks so far / emit index
    logic [MAX_PROCESSES-1:0] fin_reg, fin_next;
    logic                  bad_reg, bad_next;
    logic                  roll_reg, roll_next;    // applying a rollback
    logic                  mode_reg, mode_next;    // 1: test belongs to a request
    logic                  safe_reg, safe_next;
    status_t               status_reg, status_next;
    logic                  mv_reg, mv_next;
    bsa_out_t              md_reg, md_next;

    logic [RIW-1:0]        res_idx;
    logic [PIW-1:0]        proc_idx, scan_idx, placed_idx;
    logic                  res_last, out_free, in_safety;
    logic                  p_in, r_in;
    logic [COUNT_BITS-1:0] amt_in, amt_item;
    logic                  bad_now;

    assign res_idx    = res_reg[RIW-1:0];
    assign proc_idx   = proc_reg[PIW-1:0];
    assign scan_idx   = scan_reg[PIW-1:0];
    assign placed_idx = placed_reg[PIW-1:0];
    assign res_last   = (res_reg == rc_reg - 1'b1);
    assign out_free   = !mv_reg || m_ready;
    assign p_in       = int'(s_data.process_id) < MAX_PROCESSES;
    assign r_in       = int'(s_data.resource_id) < MAX_RESOURCES;
    assign amt_in     = COUNT_BITS'(s_data.amount);
    assign amt_item   = COUNT_BITS'(item_reg.amount);
    assign in_safety  = state_reg inside {S_SCAN, S_FIT_RD, S_FIT_EX, S_ADD_RD, S_ADD_EX};
    assign bad_now    = bad_reg || (pend_rd > need_rd) || (pend_rd > avail_rd);

    // read addresses follow the loop counters every cycle
    assign mat_raddr = in_safety ? mat_addr(scan_idx, res_idx) : mat_addr(proc_idx, res_idx);
    // writes in idle come straight from the incoming beat
    assign mat_waddr = (state_reg == S_IDLE)
                     ? mat_addr(PIW'(s_data.process_id), RIW'(s_data.resource_id))
                     : mat_addr(proc_idx, res_idx);
    assign vec_waddr = (state_reg == S_IDLE) ? RIW'(s_data.resource_id) : res_idx;

    always_ff @(posedge aclk) begin
        if (need_we) need_mem[mat_waddr] <= need_wd;
        need_rd <= need_mem[mat_raddr];
    end

    always_ff @(posedge aclk) begin
        if (alloc_we) alloc_mem[mat_waddr] <= alloc_wd;
        alloc_rd <= alloc_mem[mat_raddr];
    end

    always_ff @(posedge aclk) begin
        if (avail_we) avail_mem[vec_waddr] <= avail_wd;
        avail_rd <= avail_mem[res_idx];
    end

    always_ff @(posedge aclk) begin
        if (pend_we) pend_mem[vec_waddr] <= pend_wd;
        pend_rd <= pend_mem[res_idx];
    end

    always_ff @(posedge aclk) begin
        if (work_we) work_mem[res_idx] <= work_wd;
        work_rd <= work_mem[res_idx];
    end

    always_ff @(posedge aclk) begin
        if (order_we) order_mem[placed_idx] <= order_wd;
        order_rd <= order_mem[placed_idx];
    end

    // ------------------------------------------------------------------
    // configuration: counts saturate into 1..max
    // ------------------------------------------------------------------
    always_comb begin
        pc_next = pc_reg;
        rc_next = rc_reg;
        if (cfg_we) begin
            case (cfg_index)
                REG_PROCESS_COUNT: begin
                    if (cfg_wdata == '0)
                        pc_next = PCW'(1);
                    else if (int'(cfg_wdata) > MAX_PROCESSES)
                        pc_next = PCW'(MAX_PROCESSES);
                    else
                        pc_next = PCW'(cfg_wdata);
                end
                REG_RESOURCE_COUNT: begin
                    if (cfg_wdata == '0)
                        rc_next = RCW'(1);
                    else if (int'(cfg_wdata) > MAX_RESOURCES)
                        rc_next = RCW'(MAX_RESOURCES);
                    else
                        rc_next = RCW'(cfg_wdata);
                end
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    always_comb begin
        state_next  = state_reg;
        item_next   = item_reg;
        proc_next   = proc_reg;
        res_next    = res_reg;
        scan_next   = scan_reg;
        placed_next = placed_reg;
        fin_next    = fin_reg;
        bad_next    = bad_reg;
        roll_next   = roll_reg;
        mode_next   = mode_reg;
        safe_next   = safe_reg;
        status_next = status_reg;
        mv_next     = mv_reg && !m_ready;
        md_next     = md_reg;

        need_we  = 1'b0;  need_wd  = '0;
        alloc_we = 1'b0;  alloc_wd = '0;
        avail_we = 1'b0;  avail_wd = '0;
        pend_we  = 1'b0;  pend_wd  = '0;
        work_we  = 1'b0;  work_wd  = '0;
        order_we = 1'b0;  order_wd = '0;

        case (state_reg)
            S_CLEAR: begin
                need_we  = 1'b1;
                alloc_we = 1'b1;
                avail_we = 1'b1;
                pend_we  = 1'b1;
                if (res_reg == RCW'(MAX_RESOURCES - 1)) begin
                    res_next = '0;
                    if (proc_reg == PCW'(MAX_PROCESSES - 1))
                        state_next = S_IDLE;
                    else
                        proc_next = proc_reg + 1'b1;
                end else begin
                    res_next = res_reg + 1'b1;
                end
            end

            S_IDLE: begin
                if (s_valid) begin
                    item_next = s_data;
                    proc_next = PCW'(s_data.process_id);
                    res_next  = RCW'(s_data.resource_id);
                    case (s_data.action)
                        ACT_LOAD_AVAIL: begin
                            avail_we = r_in;
                            avail_wd = amt_in;
                        end
                        ACT_LOAD_NEED: begin
                            need_we = p_in && r_in;
                            need_wd = amt_in;
                        end
                        ACT_LOAD_ALLOC: begin
                            if (p_in && r_in)
                                state_next = S_ALLOC_RD;
                        end
                        ACT_REQUEST: begin
                            pend_we = r_in;
                            pend_wd = amt_in;
                            if (s_data.last_element) begin
                                res_next = '0;
                                bad_next = 1'b0;
                                if (int'(s_data.process_id) >= int'(pc_reg)) begin
                                    status_next = STAT_INVALID;
                                    state_next  = S_PCLR;
                                end else begin
                                    state_next = S_VAL_RD;
                                end
                            end
                        end
                        ACT_CHECK: begin
                            res_next   = '0;
                            mode_next  = 1'b0;
                            state_next = S_INIT_RD;
                        end
                        default: ;
                    endcase
                end
            end

            S_ALLOC_RD: state_next = S_ALLOC_EX;

            S_ALLOC_EX: begin
                if (amt_item > need_rd) begin
                    status_next = STAT_LOAD_ERR;
                    state_next  = S_EMIT;
                end else begin
                    alloc_we   = 1'b1;
                    alloc_wd   = amt_item;
                    need_we    = 1'b1;
                    need_wd    = need_rd - amt_item;
                    state_next = S_IDLE;
                end
            end

            S_VAL_RD: state_next = S_VAL_EX;

            S_VAL_EX: begin
                bad_next = bad_now;
                if (res_last) begin
                    res_next = '0;
                    if (bad_now) begin
                        status_next = STAT_INVALID;
                        state_next  = S_PCLR;
                    end else begin
                        roll_next  = 1'b0;
                        state_next = S_APP_RD;
                    end
                end else begin
                    res_next   = res_reg + 1'b1;
                    state_next = S_VAL_RD;
                end
            end

            S_APP_RD: state_next = S_APP_EX;

            S_APP_EX: begin
                avail_we = 1'b1;
                alloc_we = 1'b1;
                need_we  = 1'b1;
                if (roll_reg) begin
                    avail_wd = avail_rd + pend_rd;
                    alloc_wd = alloc_rd - pend_rd;
                    need_wd  = need_rd + pend_rd;
                end else begin
                    avail_wd = avail_rd - pend_rd;
                    alloc_wd = alloc_rd + pend_rd;
                    need_wd  = need_rd - pend_rd;
                end
                if (res_last) begin
                    res_next = '0;
                    if (roll_reg) begin
                        status_next = STAT_DENIED;
                        state_next  = S_PCLR;
                    end else begin
                        mode_next  = 1'b1;
                        state_next = S_INIT_RD;
                    end
                end else begin
                    res_next   = res_reg + 1'b1;
                    state_next = S_APP_RD;
                end
            end

            S_INIT_RD: state_next = S_INIT_EX;

            S_INIT_EX: begin
                work_we = 1'b1;
                work_wd = WW'(avail_rd);
                if (res_last) begin
                    res_next    = '0;
                    scan_next   = '0;
                    placed_next = '0;
                    fin_next    = '0;
                    state_next  = S_SCAN;
                end else begin
                    res_next   = res_reg + 1'b1;
                    state_next = S_INIT_RD;
                end
            end

            S_SCAN: begin
                if (scan_reg == pc_reg) begin
                    // full pass without a pick
                    safe_next  = 1'b0;
                    state_next = S_RESOLVE;
                end else if (fin_reg[scan_idx]) begin
                    scan_next = scan_reg + 1'b1;
                end else begin
                    res_next   = '0;
                    state_next = S_FIT_RD;
                end
            end

            S_FIT_RD: state_next = S_FIT_EX;

            S_FIT_EX: begin
                if (WW'(need_rd) > work_rd) begin
                    scan_next  = scan_reg + 1'b1;
                    state_next = S_SCAN;
                end else if (res_last) begin
                    res_next   = '0;
                    state_next = S_ADD_RD;
                end else begin
                    res_next   = res_reg + 1'b1;
                    state_next = S_FIT_RD;
                end
            end

            S_ADD_RD: state_next = S_ADD_EX;

            S_ADD_EX: begin
                work_we = 1'b1;
                work_wd = work_rd + WW'(alloc_rd);
                if (res_last) begin
                    fin_next[scan_idx] = 1'b1;
                    order_we    = 1'b1;
                    order_wd    = scan_idx;
                    placed_next = placed_reg + 1'b1;
                    if (PCW'(placed_reg + 1'b1) == pc_reg) begin
                        safe_next  = 1'b1;
                        state_next = S_RESOLVE;
                    end else begin
                        scan_next  = '0;
                        state_next = S_SCAN;
                    end
                end else begin
                    res_next   = res_reg + 1'b1;
                    state_next = S_ADD_RD;
                end
            end

            S_RESOLVE: begin
                res_next = '0;
                if (mode_reg) begin
                    if (safe_reg) begin
                        status_next = STAT_GRANTED;
                        state_next  = S_PCLR;
                    end else begin
                        roll_next  = 1'b1;
                        state_next = S_APP_RD;
                    end
                end else if (safe_reg) begin
                    placed_next = '0;
                    state_next  = S_ORD_RD;
                end else begin
                    status_next = STAT_UNSAFE;
                    state_next  = S_EMIT;
                end
            end

            S_PCLR: begin
                // whole pending vector back to zero
                pend_we = 1'b1;
                if (res_reg == RCW'(MAX_RESOURCES - 1))
                    state_next = S_EMIT;
                else
                    res_next = res_reg + 1'b1;
            end

            S_EMIT: begin
                if (out_free) begin
                    mv_next                  = 1'b1;
                    md_next.status           = status_reg;
                    md_next.order_process    = '0;
                    md_next.order_valid      = 1'b0;
                    md_next.last             = 1'b1;
                    state_next               = S_IDLE;
                end
            end

            S_ORD_RD: state_next = S_ORD_EX;

            S_ORD_EX: begin
                if (out_free) begin
                    mv_next               = 1'b1;
                    md_next.status        = STAT_SAFE;
                    md_next.order_process = 4'(order_rd);
                    md_next.order_valid   = 1'b1;
                    md_next.last          = (placed_reg == pc_reg - 1'b1);
                    if (placed_reg == pc_reg - 1'b1) begin
                        state_next = S_IDLE;
                    end else begin
                        placed_next = placed_reg + 1'b1;
                        state_next  = S_ORD_RD;
                    end
                end
            end

            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
            pc_reg    <= PCW'(1);
            rc_reg    <= RCW'(1);
            proc_reg  <= '0;
            res_reg   <= '0;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            pc_reg    <= pc_next;
            rc_reg    <= rc_next;
            proc_reg  <= proc_next;
            res_reg   <= res_next;
            mv_reg    <= mv_next;
        end
    end

    always_ff @(posedge aclk) begin
        item_reg   <= item_next;
        scan_reg   <= scan_next;
        placed_reg <= placed_next;
        fin_reg    <= fin_next;
        bad_reg    <= bad_next;
        roll_reg   <= roll_next;
        mode_reg   <= mode_next;
        safe_reg   <= safe_next;
        status_reg <= status_next;
        md_reg     <= md_next;
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = mv_reg;
    assign m_data  = md_reg;

endmodule

// ===== rtl/core/bsa_checker.sv =====
// ----------------------------------------------------------------------------
// bsa_checker
// Port-level checks of the banker's safety allocator, bound to the top level.
// ----------------------------------------------------------------------------
module bsa_checker
    import bsa_pkg::*;
(
    input logic     aclk,
    input logic     aresetn,
    input logic     s_valid,
    input logic     s_ready,
    input bsa_in_t  s_data,
    input logic     m_valid,
    input logic     m_ready,
    input bsa_out_t m_data
);

    // stalled result beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result beat changed while stalled");

    // store clear runs after reset: no input taken, no result shown
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !s_ready && !m_valid)
        else $error("block active right after reset");

    // only safe-order beats carry a process index
    a_order_only_safe: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.order_valid |-> m_data.status == STAT_SAFE)
        else $error("order index on a non-safe beat");

    // every non-order outcome is a single, final beat
    a_single_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.order_valid |-> m_data.last && m_data.order_process == 4'd0)
        else $error("status beat not marked last");

endmodule

bind bankers_safety_allocator bsa_checker u_bsa_checker (.*);

// ===== sim/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the banker's safety allocator: a directed table of
// loads, requests and safety checks, then randomized scenarios, with results
// compared against an in-bench banker's algorithm model.
// ----------------------------------------------------------------------------
module tb;
    import bsa_pkg::*;

    localparam int NPROC = 16;
    localparam int NRES  = 16;
    localparam int IN_W  = $bits(bsa_in_t);

    logic       aclk;
    logic       aresetn;
    logic       cfg_we;
    logic [0:0] cfg_index;
    logic [4:0] cfg_wdata;
    logic       s_valid;
    logic       s_ready;
    bsa_in_t    s_data;
    logic       m_valid;
    logic       m_ready;
    bsa_out_t   m_data;

    bankers_safety_allocator dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    // ------------------------------------------------------------------
    // Shadow copy of the allocator state
    // ------------------------------------------------------------------
    int unsigned    n_proc, n_res;
    logic [15:0]    avail_sh [NRES];
    logic [15:0]    alloc_sh [NPROC][NRES];
    logic [15:0]    need_sh  [NPROC][NRES];
    logic [15:0]    pend_sh  [NRES];
    bsa_out_t       expected_beats[$];

    int unsigned errors;

    // Banker's safety test on the shadow; fills order, returns count placed.
    function automatic int unsigned run_safety(output logic [3:0] order [NPROC]);
        logic [20:0] work [NRES];
        bit          done [NPROC];
        int unsigned placed;
        bit          found, fits;
        placed = 0;
        for (int r = 0; r < NRES; r++) work[r] = (r < n_res) ? 21'(avail_sh[r]) : '0;
        for (int p = 0; p < NPROC; p++) begin
            done[p] = 0;
            order[p] = '0;
        end
        while (placed < n_proc) begin
            found = 0;
            for (int p = 0; p < n_proc && !found; p++) begin
                if (done[p]) continue;
                fits = 1;
                for (int r = 0; r < n_res; r++)
                    if (21'(need_sh[p][r]) > work[r]) fits = 0;
                if (fits) begin
                    done[p] = 1;
                    for (int r = 0; r < n_res; r++) work[r] += 21'(alloc_sh[p][r]);
                    order[placed] = 4'(p);
                    placed++;
                    found = 1;
                end
            end
            if (!found) break;
        end
        return placed;
    endfunction

    function automatic bsa_out_t mk(status_t st, logic [3:0] pr, logic ov, logic lst);
        bsa_out_t o;
        o.status = st; o.order_process = pr; o.order_valid = ov; o.last = lst;
        return o;
    endfunction

    // Advance the shadow by one accepted beat and queue the expected results.
    function automatic void allocator_step(bsa_in_t b);
        logic [3:0]  order [NPROC];
        int unsigned placed;
        int          p, r;
        bit          ok;
        status_t     st;
        p = b.process_id;
        r = b.resource_id;
        case (b.action)
            ACT_LOAD_AVAIL: avail_sh[r] = b.amount;
            ACT_LOAD_NEED:  need_sh[p][r] = b.amount;
            ACT_LOAD_ALLOC: begin
                if (b.amount > need_sh[p][r])
                    expected_beats.push_back(mk(STAT_LOAD_ERR, 0, 0, 1));
                else begin
                    alloc_sh[p][r] = b.amount;
                    need_sh[p][r] -= b.amount;
                end
            end
            ACT_REQUEST: begin
                pend_sh[r] = b.amount;
                if (b.last_element) begin
                    ok = (p < n_proc);
                    if (ok)
                        for (int j = 0; j < n_res; j++)
                            if (pend_sh[j] > need_sh[p][j] || pend_sh[j] > avail_sh[j])
                                ok = 0;
                    if (!ok) st = STAT_INVALID;
                    else begin
                        for (int j = 0; j < n_res; j++) begin
                            avail_sh[j] -= pend_sh[j];
                            alloc_sh[p][j] += pend_sh[j];
                            need_sh[p][j] -= pend_sh[j];
                        end
                        if (run_safety(order) == n_proc) st = STAT_GRANTED;
                        else begin
                            st = STAT_DENIED;
                            for (int j = 0; j < n_res; j++) begin
                                avail_sh[j] += pend_sh[j];
                                alloc_sh[p][j] -= pend_sh[j];
                                need_sh[p][j] += pend_sh[j];
                            end
                        end
                    end
                    for (int j = 0; j < NRES; j++) pend_sh[j] = '0;
                    expected_beats.push_back(mk(st, 0, 0, 1));
                end
            end
            ACT_CHECK: begin
                placed = run_safety(order);
                if (placed != n_proc)
                    expected_beats.push_back(mk(STAT_UNSAFE, 0, 0, 1));
                else
                    for (int j = 0; j < placed; j++)
                        expected_beats.push_back(mk(STAT_SAFE, order[j], 1, j + 1 == placed));
            end
            default: ;  // unused codes are dropped
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Clock, limit
    // ------------------------------------------------------------------
    initial begin
        aclk = 0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        #8000000;
        $display("FAIL bankers_safety_allocator");
        $finish;
    end

    // ------------------------------------------------------------------
    // Result side: random back-pressure plus one long hold-off
    // ------------------------------------------------------------------
    bit calm;          // no idling on either side
    bit hold_req;      // ask receiver for a long stall
    bit hold_done;

    initial begin
        int hold_cnt;
        m_ready   = 0;
        hold_done = 0;
        hold_cnt  = 0;
        forever begin
            @(posedge aclk);
            if (hold_req && !hold_done) begin
                // long stall counted here, sender keeps pushing meanwhile
                if (hold_cnt < 3000) begin
                    hold_cnt++;
                    m_ready <= 0;
                end else begin
                    hold_done = 1;
                    m_ready <= 1;
                end
            end else
                m_ready <= calm ? 1'b1 : ($urandom_range(99) >= 30);
        end
    end

    // Checker: sample at the edge, compare with the oldest expectation.
    always @(posedge aclk) begin
        bsa_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_beats.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result beat %p", m_data);
            end else begin
                want = expected_beats.pop_front();
                if (m_data !== want) begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: exp st=%0d proc=%0d ov=%0d last=%0d got st=%0d proc=%0d ov=%0d last=%0d",
                                 want.status, want.order_process, want.order_valid, want.last,
                                 m_data.status, m_data.order_process, m_data.order_valid,
                                 m_data.last);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------
    // valid stays up across back-to-back beats; it drops only for an idle gap
    task automatic send_beat(bsa_in_t b);
        if (!calm && $urandom_range(99) < 30) begin
            s_valid <= 0;
            do @(posedge aclk); while ($urandom_range(99) < 30);
        end
        s_valid <= 1;
        s_data  <= b;
        do @(posedge aclk); while (!s_ready);
        allocator_step(b);
    endtask

    task automatic send(action_t a, int p, int r, int amt, bit le);
        bsa_in_t b;
        b.action = a; b.process_id = 4'(p); b.resource_id = 4'(r);
        b.amount = 16'(amt); b.last_element = le;
        send_beat(b);
    endtask

    // Wait for drain, then for any quiet trailing work (worst safety test).
    task automatic settle();
        int guard;
        guard = 0;
        s_valid <= 0;
        while (expected_beats.size() != 0 && guard < 200000) begin
            @(posedge aclk);
            guard++;
        end
        repeat (3000) @(posedge aclk);
    endtask

    task automatic write_cfg(cfg_reg_t idx, int val);
        cfg_we    <= 1;
        cfg_index <= idx;
        cfg_wdata <= 5'(val);
        @(posedge aclk);
        cfg_we <= 0;
        if (idx == REG_PROCESS_COUNT)
            n_proc = (val & 31) < 1 ? 1 : ((val & 31) > NPROC ? NPROC : (val & 31));
        else
            n_res  = (val & 31) < 1 ? 1 : ((val & 31) > NRES ? NRES : (val & 31));
        @(posedge aclk);
    endtask

    // Directed table; has_exp rows carry a typed-in status, held against the latest model expectation.
    typedef struct {
        action_t    a;
        int         p, r, amt;
        bit         le;
        bit         has_exp;
        status_t    exp_st;
    } dir_row_t;

    dir_row_t dir_tab[] = '{
        '{ACT_CHECK,      0, 0, 0,     0, 1, STAT_SAFE},     // cleared stores: safe
        '{ACT_LOAD_ALLOC, 0, 0, 1,     0, 1, STAT_LOAD_ERR}, // beyond zero need
        '{ACT_LOAD_AVAIL, 0, 0, 65535, 0, 0, STAT_SAFE},
        '{ACT_LOAD_AVAIL, 0, 15, 0,    0, 0, STAT_SAFE},
        '{ACT_LOAD_NEED,  0, 0, 65535, 0, 0, STAT_SAFE},
        '{ACT_LOAD_NEED,  15, 15, 7,   0, 0, STAT_SAFE},     // outside counts in use
        '{ACT_LOAD_ALLOC, 0, 0, 65535, 0, 0, STAT_SAFE},
        '{ACT_LOAD_NEED,  1, 0, 40,    0, 0, STAT_SAFE},
        '{ACT_LOAD_ALLOC, 1, 0, 10,    0, 0, STAT_SAFE},
        '{ACT_CHECK,      0, 0, 0,     0, 0, STAT_SAFE},
        '{ACT_REQUEST,    5, 0, 1,     1, 1, STAT_INVALID},  // process not in use
        '{ACT_REQUEST,    1, 0, 31,    1, 1, STAT_INVALID},  // over need
        '{ACT_REQUEST,    1, 3, 9,     0, 0, STAT_SAFE},     // element only
        '{ACT_REQUEST,    1, 0, 5,     1, 0, STAT_SAFE},
        '{ACT_LOAD_AVAIL, 0, 0, 0,     0, 0, STAT_SAFE},
        '{ACT_LOAD_NEED,  0, 1, 50,    0, 0, STAT_SAFE},
        '{ACT_CHECK,      0, 0, 0,     0, 0, STAT_SAFE},
        '{ACT_REQUEST,    1, 0, 3,     1, 0, STAT_SAFE},
        '{ACT_CHECK,      0, 0, 0,     0, 0, STAT_SAFE}
    };

    function automatic int rnd_amt();
        case ($urandom_range(9))
            0:       return 0;
            1:       return 65535;
            2:       return $urandom_range(65535);
            default: return $urandom_range(12);
        endcase
    endfunction

    // Random scenario: loads, requests, checks and noise beats, mixed at random.
    task automatic scenario(int items);
        int          p, r, k, n;
        bsa_in_t     b;
        k = 0;
        while (k < items) begin
            n = $urandom_range(99);
            p = $urandom_range(n_proc - 1);
            r = $urandom_range(n_res - 1);
            if (n < 12) send(ACT_LOAD_AVAIL, 0, r, rnd_amt(), $urandom_range(1));
            else if (n < 24) send(ACT_LOAD_NEED, p, r, rnd_amt(), 0);
            else if (n < 34) send(ACT_LOAD_ALLOC, p, r, $urandom_range(6), 0);
            else if (n < 70) begin
                // request vector: a few elements then the marked one
                repeat ($urandom_range(n_res - 1)) begin
                    send(ACT_REQUEST, p, $urandom_range(n_res - 1), $urandom_range(4), 0);
                    k++;
                end
                send(ACT_REQUEST, ($urandom_range(9) == 0) ? $urandom_range(15) : p,
                     r, $urandom_range(4), 1);
            end else if (n < 92) send(ACT_CHECK, p, r, 0, 0);
            else begin
                // noise, including unused codes and wide indices
                b = bsa_in_t'(IN_W'($urandom));
                send_beat(b);
            end
            k++;
        end
    endtask

    initial begin
        dir_row_t row;
        errors = 0;
        calm = 0; hold_req = 0;
        n_proc = 1; n_res = 1;
        for (int r = 0; r < NRES; r++) begin
            avail_sh[r] = '0; pend_sh[r] = '0;
            for (int p = 0; p < NPROC; p++) begin
                alloc_sh[p][r] = '0; need_sh[p][r] = '0;
            end
        end
        aresetn = 0; cfg_we = 0; cfg_index = '0; cfg_wdata = '0;
        s_valid = 0; s_data = '0;
        repeat (6) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // directed part with two processes, one resource kind
        write_cfg(REG_PROCESS_COUNT, 2);
        foreach (dir_tab[i]) begin
            row = dir_tab[i];
            send(row.a, row.p, row.r, row.amt, row.le);
            if (row.has_exp && expected_beats.size() != 0 &&
                expected_beats[expected_beats.size() - 1].status != row.exp_st) begin
                errors++;
                if (errors <= 10)
                    $display("row %0d: typed status %0d, model %0d", i, row.exp_st,
                             expected_beats[expected_beats.size() - 1].status);
            end
        end
        settle();

        // config extremes incl. saturation of 0 and of 31
        write_cfg(REG_PROCESS_COUNT, 0);
        write_cfg(REG_RESOURCE_COUNT, 31);
        scenario(30);
        settle();
        write_cfg(REG_PROCESS_COUNT, 16);
        write_cfg(REG_RESOURCE_COUNT, 1);
        calm = 1;
        scenario(40);
        calm = 0;
        settle();
        write_cfg(REG_PROCESS_COUNT, 4);
        write_cfg(REG_RESOURCE_COUNT, 3);
        hold_req = 1;               // receiver stalls while checks pile up
        repeat (12) send(ACT_CHECK, 0, 0, 0, 0);
        scenario(90);
        settle();
        write_cfg(REG_PROCESS_COUNT, 6);
        write_cfg(REG_RESOURCE_COUNT, 16);
        scenario(90);
        settle();

        if (errors == 0 && expected_beats.size() == 0)
            $display("PASS bankers_safety_allocator");
        else
            $display("FAIL bankers_safety_allocator");
        $finish;
    end

endmodule
